>>> rtl/qdsd_pkg.sv
// qdsd_pkg: shared constants, beat types and sequencer states of the stability detector
`default_nettype none

package qdsd_pkg;

    // storage depths and fill threshold
    localparam int SAMPLE_DEPTH = 512;
    localparam int MATCH_DEPTH  = 1024;
    localparam int WINDOW_DEPTH = 256;
    localparam int MIN_FILL     = 30;

    // field widths
    localparam int TIME_W   = 48;
    localparam int SAMPLE_W = 24;
    localparam int DEV_W    = 32;
    localparam int SCORE_W  = 16;
    localparam int BUCKET_W = 2;
    localparam int FRAC_W   = 8;

    // ring and window pointers and counts
    localparam int SPOS_W = $clog2(SAMPLE_DEPTH);
    localparam int SCNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam int MPOS_W = $clog2(MATCH_DEPTH);
    localparam int MCNT_W = $clog2(MATCH_DEPTH + 1);
    localparam int WPOS_W = $clog2(WINDOW_DEPTH);
    localparam int WCNT_W = $clog2(WINDOW_DEPTH + 1);

    // running sums and the variance numerator
    localparam int SUM_W  = SAMPLE_W + SPOS_W + 1;
    localparam int MAG_W  = SAMPLE_W + SPOS_W;
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int QSUM_W = SQ_W + SPOS_W;
    localparam int RHS_W  = QSUM_W + SCNT_W;
    localparam int NUM_W  = RHS_W + 2 * FRAC_W;
    localparam int NN1_W  = 2 * SCNT_W;
    localparam int MULC_W = $clog2(MAG_W + 1);

    // score operands
    localparam int DOT_W    = WCNT_W + 3;
    localparam int CSQ_W    = 2 * WCNT_W;
    localparam int NORM_W   = 2 * WCNT_W + 7;
    localparam int SCORE_SH = 30;

    // shared divide and root unit
    localparam int DEN_W  = (NN1_W > NORM_W) ? NN1_W : NORM_W;
    localparam int RAD_W  = 2 * DEV_W;
    localparam int DSC_W  = $clog2(NUM_W + 1);

    // stability test
    localparam int MN1_W     = 2 * MCNT_W;
    localparam int CMP_W     = 2 * MCNT_W + 7;
    localparam int STB_SCALE = 100;
    localparam int STB_HI    = 49;
    localparam int STB_LO    = 16;

    localparam int WDATA_W = TIME_W + BUCKET_W;

    // reset values
    localparam logic [DEV_W-1:0]   DEV_RESET  = 32'd2560;
    localparam logic [SCORE_W-1:0] SCORE_ONE  = 16'd32768;
    localparam logic [TIME_W-1:0]  WLEN_RESET = 48'd1000000000;
    localparam logic [TIME_W-1:0]  SPR_RESET  = 48'd1000000000;
    localparam logic [TIME_W-1:0]  STB_RESET  = 48'd2500000000;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH    = 2'd0,
        REG_SPREAD_PERIOD    = 2'd1,
        REG_STABILITY_PERIOD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] delay_sample;
        logic [TIME_W-1:0]          now;
    } qdsd_in_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [SCORE_W-1:0]  score;
        logic                stable;
        logic [DEV_W-1:0]    spread;
    } qdsd_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_status_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT,
        DS_DONE
    } ds_phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_SQO,
        ST_ADD_SQN,
        ST_ADD_WR,
        ST_SPR_CHK,
        ST_MUL_N,
        ST_MUL_S,
        ST_DEV_DIV,
        ST_DEV_WAIT,
        ST_BUCKET,
        ST_WIN_RD,
        ST_WIN_DROP,
        ST_WIN_PUSH,
        ST_EVC_RD,
        ST_EVC_CHK,
        ST_SC_PREP,
        ST_SC_NORM,
        ST_SC_DIV,
        ST_SC_WAIT,
        ST_MT_RD,
        ST_MT_UPD,
        ST_STB_CHK,
        ST_STB_CMP,
        ST_DONE
    } qdsd_state_t;

endpackage

`default_nettype wire

>>> rtl/qdsd_ram.sv
// qdsd_ram: generic single-write, single-read memory with registered read data
`default_nettype none

module qdsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/qdsd_divsqrt.sv
// qdsd_divsqrt: bit-serial floor(sqrt(floor(num / den))) with a saturated root
`default_nettype none

module qdsd_divsqrt import qdsd_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output ds_status_t            status,
    output logic      [DEV_W-1:0] root
);

    ds_phase_t          phase_reg, phase_next;
    logic [DSC_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [DEV_W+1:0]   srem_reg;
    logic [DEV_W-1:0]   root_reg;

    logic [DEN_W:0]     div_trial;
    logic               div_bit;
    logic [DEN_W-1:0]   rem_step;
    logic [NUM_W-1:0]   quo_step;
    logic [RAD_W-1:0]   rad_load;
    logic [DEV_W+3:0]   sq_trial;
    logic [DEV_W+3:0]   sq_sub;
    logic               sq_bit;

    // one restoring divide step
    always_comb begin
        div_trial = {rem_reg, quo_reg[NUM_W-1]};
        div_bit   = (div_trial >= {1'b0, den_reg});
        rem_step  = div_bit ? DEN_W'(div_trial - {1'b0, den_reg}) : div_trial[DEN_W-1:0];
        quo_step  = {quo_reg[NUM_W-2:0], div_bit};
        rad_load  = (|quo_step[NUM_W-1:RAD_W]) ? {RAD_W{1'b1}} : quo_step[RAD_W-1:0];
    end

    // one restoring root step, two radicand bits at a time
    always_comb begin
        sq_trial = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        sq_sub   = (DEV_W+4)'({root_reg, 2'b01});
        sq_bit   = (sq_trial >= sq_sub);
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            DS_IDLE: begin
                if (start) phase_next = DS_DIV;
            end
            DS_DIV: begin
                if (cnt_reg == DSC_W'(1)) phase_next = DS_SQRT;
            end
            DS_SQRT: begin
                if (cnt_reg == DSC_W'(1)) phase_next = DS_DONE;
            end
            DS_DONE: phase_next = DS_IDLE;
            default: phase_next = DS_IDLE;
        endcase
    end

    // status outputs
    always_comb begin
        status.busy = (phase_reg != DS_IDLE);
        status.done = (phase_reg == DS_DONE);
    end

    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= DS_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // divide and root datapath
    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            DS_IDLE: begin
                quo_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                cnt_reg <= DSC_W'(NUM_W);
            end
            DS_DIV: begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - DSC_W'(1);
                if (cnt_reg == DSC_W'(1)) begin
                    rad_reg  <= rad_load;
                    srem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg  <= DSC_W'(DEV_W);
                end
            end
            DS_SQRT: begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                srem_reg <= sq_bit ? (DEV_W+2)'(sq_trial - sq_sub) : (DEV_W+2)'(sq_trial);
                root_reg <= {root_reg[DEV_W-2:0], sq_bit};
                cnt_reg  <= cnt_reg - DSC_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/queue_delay_stability_detector_unit.sv
// queue_delay_stability_detector_unit: top level of the queue-delay stability detector
`default_nettype none

// One beat in, one beat out. An add beat steps through the sample read, both squares,
// the sample write, the spread check, bucketing and the window push. A full window store
// first drops its oldest entry, and each window entry that has aged out is dropped. When
// the spread period has run out and at least 30 samples are held, the add also runs a
// serial multiply for the variance numerator and the shared bit-serial divide and square
// root unit. An evaluate beat uses the same shared unit when any window entry sits in
// bucket 1 or 2. Running sums of the samples, their squares and the repeat bits are kept
// up to date, so no ring is walked. No clearing pass follows reset. The input is not
// ready while a beat is at work; a finished result waits in the output register.
module queue_delay_stability_detector_unit import qdsd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qdsd_in_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qdsd_out_t              m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [TIME_W-1:0] cfg_data
);

    qdsd_state_t state_reg, state_next;
    qdsd_in_t    item_reg;

    // configuration
    logic [TIME_W-1:0] wlen_reg, spr_per_reg, stb_per_reg;

    // sample ring state
    logic [SPOS_W-1:0]       spos_reg;
    logic                    sfull_reg;
    logic signed [SUM_W-1:0] ssum_reg;
    logic [QSUM_W-1:0]       qsum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DEV_W-1:0]        dev_reg;
    logic [TIME_W-1:0]       last_spr_reg;

    // serial multiply for the variance numerator
    logic [RHS_W-1:0]  acc_reg, ma_reg;
    logic [MAG_W-1:0]  mb_reg;
    logic [MULC_W-1:0] mcnt_reg;
    logic [NN1_W-1:0]  nn1_reg;

    // window state
    logic [WPOS_W-1:0] whead_reg;
    logic [WCNT_W-1:0] wfill_reg;
    logic [WCNT_W-1:0] counts_reg [3];
    logic [BUCKET_W-1:0] bk_reg;

    // score
    logic [CSQ_W-1:0]   csq_reg [3];
    logic [DOT_W-1:0]   dot_reg;
    logic [2*DOT_W-1:0] dotsq_reg;
    logic [NORM_W-1:0]  norm_reg;
    logic [SCORE_W-1:0] score_reg, prev_score_reg;

    // repeat-bit ring state
    logic [MPOS_W-1:0] mpos_reg;
    logic              mfull_reg;
    logic [MCNT_W-1:0] kcnt_reg;
    logic [TIME_W-1:0] last_stb_reg;
    logic              stable_reg;
    logic [MN1_W-1:0]  p_reg, mn1_reg;

    logic      m_valid_reg;
    qdsd_out_t m_data_reg;

    // memory ports
    logic                    samp_we;
    logic [SAMPLE_W-1:0]     samp_rdata;
    logic                    win_we;
    logic [WPOS_W-1:0]       win_waddr, win_raddr;
    logic [WDATA_W-1:0]      win_wdata, win_rdata;
    logic                    mt_we;
    logic [0:0]              mt_wdata, mt_rdata;

    // shared divide and root unit
    logic             ds_start;
    logic [NUM_W-1:0] ds_num;
    logic [DEN_W-1:0] ds_den;
    ds_status_t       ds_status;
    logic [DEV_W-1:0] ds_root;

    // derived values
    logic [SCNT_W-1:0]       scnt;
    logic [MCNT_W-1:0]       mcnt;
    logic                    spr_due, stb_due;
    logic [TIME_W-1:0]       spr_age, stb_age, win_age;
    logic signed [SAMPLE_W-1:0] sq_op;
    logic signed [SQ_W-1:0]  sq_prod;
    logic signed [SUM_W-1:0] old_ext;
    logic [MAG_W-1:0]        ssum_mag;
    logic signed [DEV_W+2:0] s8_x, dev2_x, dev4_x;
    logic [BUCKET_W-1:0]     bk_calc;
    logic [WCNT_W:0]         slot_sum;
    logic [WPOS_W-1:0]       slot;
    logic [WPOS_W-1:0]       whead_inc;
    logic [BUCKET_W-1:0]     old_bk;
    logic [TIME_W-1:0]       old_stamp;
    logic                    aged;
    logic                    win_drop, win_push;
    logic [DOT_W-1:0]        dot_calc;
    logic [NORM_W-1:0]       csq_sum;
    logic                    match_bit;
    logic [CMP_W-1:0]        stb_lhs, stb_hi, stb_lo;
    logic [SCORE_W-1:0]      score_calc;

    always_comb begin
        scnt     = sfull_reg ? SCNT_W'(SAMPLE_DEPTH) : SCNT_W'(spos_reg);
        mcnt     = mfull_reg ? MCNT_W'(MATCH_DEPTH) : MCNT_W'(mpos_reg);
        spr_age  = item_reg.now - last_spr_reg;
        stb_age  = item_reg.now - last_stb_reg;
        spr_due  = (spr_age > spr_per_reg);
        stb_due  = (stb_age > stb_per_reg);
        old_bk    = win_rdata[BUCKET_W-1:0];
        old_stamp = win_rdata[WDATA_W-1:BUCKET_W];
        win_age   = item_reg.now - old_stamp;
        aged      = (win_age > wlen_reg);
    end

    // shared squarer: old sample first, then the new one
    always_comb begin
        sq_op   = (state_reg == ST_ADD_SQO) ? $signed(samp_rdata) : item_reg.delay_sample;
        sq_prod = sq_op * sq_op;
        old_ext = sfull_reg ? SUM_W'($signed(samp_rdata)) : '0;
        ssum_mag = ssum_reg[SUM_W-1] ? MAG_W'(-ssum_reg) : MAG_W'(ssum_reg);
    end

    // bucket against twice and four times the deviation
    always_comb begin
        s8_x   = $signed({{(DEV_W+3-SAMPLE_W-FRAC_W){item_reg.delay_sample[SAMPLE_W-1]}},
                          item_reg.delay_sample, {FRAC_W{1'b0}}});
        dev2_x = $signed({2'b00, dev_reg, 1'b0});
        dev4_x = $signed({1'b0, dev_reg, 2'b00});
        priority if (s8_x <= dev2_x) bk_calc = 2'd0;
        else if (s8_x <= dev4_x)     bk_calc = 2'd1;
        else                         bk_calc = 2'd2;
    end

    // window slot arithmetic
    always_comb begin
        slot_sum  = (WCNT_W+1)'(whead_reg) + (WCNT_W+1)'(wfill_reg);
        slot      = (slot_sum >= (WCNT_W+1)'(WINDOW_DEPTH))
                    ? WPOS_W'(slot_sum - (WCNT_W+1)'(WINDOW_DEPTH)) : WPOS_W'(slot_sum);
        whead_inc = (whead_reg == WPOS_W'(WINDOW_DEPTH - 1)) ? '0 : whead_reg + WPOS_W'(1);
        win_drop  = (state_reg == ST_WIN_DROP) || ((state_reg == ST_EVC_CHK) && aged);
        win_push  = (state_reg == ST_WIN_PUSH);
    end

    // score and stability operands
    always_comb begin
        dot_calc   = DOT_W'(counts_reg[1]) + (DOT_W'(counts_reg[2]) << 2);
        csq_sum    = NORM_W'(csq_reg[0]) + NORM_W'(csq_reg[1]) + NORM_W'(csq_reg[2]);
        match_bit  = (score_reg == prev_score_reg);
        stb_lhs    = CMP_W'(p_reg) * CMP_W'(STB_SCALE);
        stb_hi     = CMP_W'(mn1_reg) * CMP_W'(STB_HI);
        stb_lo     = CMP_W'(mn1_reg) * CMP_W'(STB_LO);
        score_calc = (ds_root >= DEV_W'(SCORE_ONE))
                     ? '0 : SCORE_ONE - ds_root[SCORE_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = (s_data.op == OP_ADD) ? ST_ADD_RD : ST_SC_PREP;
            end
            ST_ADD_RD:  state_next = ST_ADD_SQO;
            ST_ADD_SQO: state_next = ST_ADD_SQN;
            ST_ADD_SQN: state_next = ST_ADD_WR;
            ST_ADD_WR:  state_next = ST_SPR_CHK;
            ST_SPR_CHK: begin
                state_next = (spr_due && scnt >= SCNT_W'(MIN_FILL)) ? ST_MUL_N : ST_BUCKET;
            end
            ST_MUL_N: begin
                if (mcnt_reg == MULC_W'(1)) state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                if (mcnt_reg == MULC_W'(1)) state_next = ST_DEV_DIV;
            end
            ST_DEV_DIV: state_next = ST_DEV_WAIT;
            ST_DEV_WAIT: begin
                if (ds_status.done) state_next = ST_BUCKET;
            end
            ST_BUCKET: begin
                state_next = (wfill_reg == WCNT_W'(WINDOW_DEPTH)) ? ST_WIN_RD : ST_WIN_PUSH;
            end
            ST_WIN_RD:   state_next = ST_WIN_DROP;
            ST_WIN_DROP: state_next = ST_WIN_PUSH;
            ST_WIN_PUSH: state_next = ST_EVC_RD;
            ST_EVC_RD: begin
                state_next = (wfill_reg > WCNT_W'(1)) ? ST_EVC_CHK : ST_DONE;
            end
            ST_EVC_CHK: state_next = aged ? ST_EVC_RD : ST_DONE;
            ST_SC_PREP: state_next = (dot_calc == '0) ? ST_MT_RD : ST_SC_NORM;
            ST_SC_NORM: state_next = ST_SC_DIV;
            ST_SC_DIV:  state_next = ST_SC_WAIT;
            ST_SC_WAIT: begin
                if (ds_status.done) state_next = ST_MT_RD;
            end
            ST_MT_RD:  state_next = ST_MT_UPD;
            ST_MT_UPD: state_next = ST_STB_CHK;
            ST_STB_CHK: begin
                state_next = (stb_due && mcnt >= MCNT_W'(MIN_FILL)) ? ST_STB_CMP : ST_DONE;
            end
            ST_STB_CMP: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        samp_we   = 1'b0;
        win_we    = 1'b0;
        win_raddr = whead_reg;
        win_waddr = slot;
        win_wdata = {item_reg.now, bk_reg};
        mt_we     = 1'b0;
        mt_wdata  = match_bit;
        ds_start  = 1'b0;
        ds_num    = {acc_reg, {(2*FRAC_W){1'b0}}};
        ds_den    = DEN_W'(nn1_reg);
        unique case (state_reg)
            ST_IDLE:     s_ready  = 1'b1;
            ST_ADD_WR:   samp_we  = 1'b1;
            ST_DEV_DIV:  ds_start = 1'b1;
            ST_WIN_PUSH: win_we   = 1'b1;
            ST_SC_DIV: begin
                ds_start = 1'b1;
                ds_num   = NUM_W'({dotsq_reg, {SCORE_SH{1'b0}}});
                ds_den   = DEN_W'(norm_reg);
            end
            ST_MT_UPD:   mt_we    = 1'b1;
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= WLEN_RESET;
            spr_per_reg <= SPR_RESET;
            stb_per_reg <= STB_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:    wlen_reg    <= cfg_data;
                REG_SPREAD_PERIOD:    spr_per_reg <= cfg_data;
                REG_STABILITY_PERIOD: stb_per_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control state and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            spos_reg       <= '0;
            sfull_reg      <= 1'b0;
            ssum_reg       <= '0;
            qsum_reg       <= '0;
            dev_reg        <= DEV_RESET;
            last_spr_reg   <= '0;
            whead_reg      <= '0;
            wfill_reg      <= '0;
            for (int j = 0; j < 3; j++) counts_reg[j] <= '0;
            prev_score_reg <= SCORE_ONE;
            mpos_reg       <= '0;
            mfull_reg      <= 1'b0;
            kcnt_reg       <= '0;
            last_stb_reg   <= '0;
            stable_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // running sums of the sample ring
            if (state_reg == ST_ADD_SQO) begin
                ssum_reg <= ssum_reg - old_ext + SUM_W'(item_reg.delay_sample);
            end
            if (state_reg == ST_ADD_SQN && sfull_reg) begin
                qsum_reg <= qsum_reg - QSUM_W'(sq_reg);
            end
            if (state_reg == ST_ADD_WR) begin
                qsum_reg <= qsum_reg + QSUM_W'(sq_reg);
                if (spos_reg == SPOS_W'(SAMPLE_DEPTH - 1)) begin
                    spos_reg  <= '0;
                    sfull_reg <= 1'b1;
                end else begin
                    spos_reg <= spos_reg + SPOS_W'(1);
                end
            end
            if (state_reg == ST_SPR_CHK && spr_due) begin
                last_spr_reg <= item_reg.now;
            end
            if (state_reg == ST_DEV_WAIT && ds_status.done) begin
                dev_reg <= ds_root;
            end

            // window counts, head and fill
            for (int j = 0; j < 3; j++) begin
                if (win_drop && old_bk == BUCKET_W'(j) && counts_reg[j] != '0) begin
                    counts_reg[j] <= counts_reg[j] - WCNT_W'(1);
                end else if (win_push && bk_reg == BUCKET_W'(j)) begin
                    counts_reg[j] <= counts_reg[j] + WCNT_W'(1);
                end
            end
            if (win_drop) begin
                whead_reg <= whead_inc;
                wfill_reg <= wfill_reg - WCNT_W'(1);
            end else if (win_push) begin
                wfill_reg <= wfill_reg + WCNT_W'(1);
            end

            // repeat-bit ring and stability flag
            if (state_reg == ST_MT_UPD) begin
                kcnt_reg <= kcnt_reg - MCNT_W'(mfull_reg & mt_rdata[0]) + MCNT_W'(match_bit);
                prev_score_reg <= score_reg;
                if (mpos_reg == MPOS_W'(MATCH_DEPTH - 1)) begin
                    mpos_reg  <= '0;
                    mfull_reg <= 1'b1;
                end else begin
                    mpos_reg <= mpos_reg + MPOS_W'(1);
                end
            end
            if (state_reg == ST_STB_CHK && stb_due) begin
                last_stb_reg <= item_reg.now;
            end
            if (state_reg == ST_STB_CMP) begin
                stable_reg <= stable_reg ? (stb_lhs < stb_hi) : (stb_lhs < stb_lo);
            end

            // output register
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) item_reg <= s_data;
                bk_reg <= '0;
            end
            ST_ADD_SQO, ST_ADD_SQN: sq_reg <= SQ_W'(unsigned'(sq_prod));
            ST_SPR_CHK: begin
                acc_reg  <= '0;
                ma_reg   <= RHS_W'(qsum_reg);
                mb_reg   <= MAG_W'(scnt);
                mcnt_reg <= MULC_W'(SCNT_W);
                nn1_reg  <= NN1_W'(scnt) * NN1_W'(scnt - SCNT_W'(1));
            end
            ST_MUL_N: begin
                if (mb_reg[0]) acc_reg <= acc_reg + ma_reg;
                ma_reg   <= ma_reg << 1;
                mb_reg   <= mb_reg >> 1;
                mcnt_reg <= mcnt_reg - MULC_W'(1);
                if (mcnt_reg == MULC_W'(1)) begin
                    ma_reg   <= RHS_W'(ssum_mag);
                    mb_reg   <= ssum_mag;
                    mcnt_reg <= MULC_W'(MAG_W);
                end
            end
            ST_MUL_S: begin
                if (mb_reg[0]) acc_reg <= acc_reg - ma_reg;
                ma_reg   <= ma_reg << 1;
                mb_reg   <= mb_reg >> 1;
                mcnt_reg <= mcnt_reg - MULC_W'(1);
            end
            ST_BUCKET: bk_reg <= bk_calc;
            ST_SC_PREP: begin
                for (int j = 0; j < 3; j++) begin
                    csq_reg[j] <= CSQ_W'(counts_reg[j]) * CSQ_W'(counts_reg[j]);
                end
                dot_reg   <= dot_calc;
                score_reg <= SCORE_ONE;
            end
            ST_SC_NORM: begin
                norm_reg  <= (csq_sum << 4) + csq_sum;
                dotsq_reg <= (2*DOT_W)'(dot_reg) * (2*DOT_W)'(dot_reg);
            end
            ST_SC_WAIT: begin
                if (ds_status.done) score_reg <= score_calc;
            end
            ST_STB_CHK: begin
                p_reg   <= MN1_W'(kcnt_reg) * MN1_W'(mcnt - kcnt_reg);
                mn1_reg <= MN1_W'(mcnt) * MN1_W'(mcnt - MCNT_W'(1));
            end
            ST_DONE: begin
                // load only once the previous result has left
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.bucket <= bk_reg;
                    m_data_reg.score  <= prev_score_reg;
                    m_data_reg.stable <= stable_reg;
                    m_data_reg.spread <= dev_reg;
                end
            end
            default: begin
            end
        endcase
    end

    qdsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (samp_we),
        .waddr (spos_reg),
        .wdata (item_reg.delay_sample),
        .raddr (spos_reg),
        .rdata (samp_rdata)
    );

    qdsd_ram #(
        .WIDTH (WDATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    qdsd_ram #(
        .WIDTH (1),
        .DEPTH (MATCH_DEPTH)
    ) u_match_ram (
        .aclk  (aclk),
        .we    (mt_we),
        .waddr (mpos_reg),
        .wdata (mt_wdata),
        .raddr (mpos_reg),
        .rdata (mt_rdata)
    );

    qdsd_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ds_start),
        .num     (ds_num),
        .den     (ds_den),
        .status  (ds_status),
        .root    (ds_root)
    );

`ifndef NO_ASSERTIONS
    // one beat at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is at work");

    // window never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        wfill_reg <= WCNT_W'(WINDOW_DEPTH))
        else $error("window fill beyond depth");

    // bucket counts track the window contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |->
        ((WCNT_W+2)'(counts_reg[0]) + (WCNT_W+2)'(counts_reg[1])
         + (WCNT_W+2)'(counts_reg[2])) == (WCNT_W+2)'(wfill_reg))
        else $error("bucket counts disagree with window fill");

    // result fields stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.score <= SCORE_ONE) && (m_data.bucket != 2'd3))
        else $error("result field out of range");

    // divide unit only started when idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ds_start |-> !ds_status.busy)
        else $error("divide unit restarted while busy");
`endif

endmodule

`default_nettype wire
